// ----- hdl/caldate_pkg.sv -----
package caldate_pkg;

    localparam int DAY_BITS   = 5;
    localparam int MONTH_BITS = 4;
    localparam int YEAR_PORT_BITS = 16;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_NEXT = 2'd1,
        OP_PREV = 2'd2,
        OP_CMP  = 2'd3
    } caldate_op_t;

    typedef struct packed {
        logic rejected;
        logic earlier;
        logic equal;
    } caldate_flags_t;

    localparam logic [DAY_BITS-1:0]   DEFAULT_DAY   = 5'd1;
    localparam logic [MONTH_BITS-1:0] DEFAULT_MONTH = 4'd1;
    localparam int                    DEFAULT_YEAR  = 1999;

    localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_BITS-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_BITS-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_BITS-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_BITS-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_BITS-1:0] LEN_LONG  = 5'd31;
    localparam logic [DAY_BITS-1:0] LEN_SHORT = 5'd30;
    localparam logic [DAY_BITS-1:0] LEN_FEB_LEAP = 5'd29;
    localparam logic [DAY_BITS-1:0] LEN_FEB   = 5'd28;
    localparam logic [DAY_BITS-1:0] LEN_NONE  = 5'd0;

    // days in a month, zero for a month code outside jan..dec
    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                      input logic leap);
        logic [DAY_BITS-1:0] len;
        unique case (m)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: len = LEN_LONG;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
            default: len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

// ----- hdl/caldate_leap.sv -----
module caldate_leap #(
    parameter int YEAR_BITS = 16
) (
    input  logic [YEAR_BITS-1:0] year,
    output logic                 leap
);

    // odd factor of 100 and 400; divisibility by it is tested with the
    // modular inverse: y*inv mod 2^n is at most (2^n-1)/f exactly for multiples
    localparam logic [63:0] CENTURY_FACTOR = 64'd25;

    function automatic logic [63:0] inv_pow2(input logic [63:0] a);
        logic [63:0] x;
        x = a;
        for (int i = 0; i < 6; i++) begin
            x = x * (64'd2 - a * x);
        end
        return x;
    endfunction

    localparam logic [YEAR_BITS-1:0] INV_FACTOR = YEAR_BITS'(inv_pow2(CENTURY_FACTOR));
    localparam logic [YEAR_BITS-1:0] LIM_FACTOR =
        YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / CENTURY_FACTOR);

    logic [YEAR_BITS-1:0] prod;
    logic                 mult_of_factor;

    assign prod           = year * INV_FACTOR;
    assign mult_of_factor = (prod <= LIM_FACTOR);

    // div by 4, and if div by 100 then also by 16 (so by 400)
    assign leap = (year[1:0] == 2'b00) && (!mult_of_factor || (year[3:0] == 4'b0000));

endmodule

// ----- hdl/caldate_update.sv -----
module caldate_update #(
    parameter int YEAR_BITS     = 16,
    parameter int MIN_LOAD_YEAR = 1000
) (
    input  caldate_pkg::caldate_op_t                op,
    input  logic [caldate_pkg::DAY_BITS-1:0]        day_in,
    input  logic [caldate_pkg::MONTH_BITS-1:0]      month_in,
    input  logic [YEAR_BITS-1:0]                    year_in,
    input  logic [caldate_pkg::DAY_BITS-1:0]        cur_day,
    input  logic [caldate_pkg::MONTH_BITS-1:0]      cur_month,
    input  logic [YEAR_BITS-1:0]                    cur_year,
    output logic [caldate_pkg::DAY_BITS-1:0]        day_new,
    output logic [caldate_pkg::MONTH_BITS-1:0]      month_new,
    output logic [YEAR_BITS-1:0]                    year_new,
    output caldate_pkg::caldate_flags_t             flags
);

    localparam logic [YEAR_BITS-1:0] YEAR_MAX  = {YEAR_BITS{1'b1}};
    localparam logic [YEAR_BITS-1:0] YEAR_DFLT = YEAR_BITS'(caldate_pkg::DEFAULT_YEAR);
    localparam logic [31:0]          YEAR_MIN  = 32'(MIN_LOAD_YEAR);

    logic                               leap_in;
    logic                               leap_cur;
    logic [caldate_pkg::DAY_BITS-1:0]   len_in;
    logic [caldate_pkg::DAY_BITS-1:0]   len_cur;
    logic [caldate_pkg::DAY_BITS-1:0]   len_prev;
    logic [caldate_pkg::MONTH_BITS-1:0] month_prev;
    logic                               load_ok;

    caldate_leap #(.YEAR_BITS(YEAR_BITS)) u_leap_in (
        .year (year_in),
        .leap (leap_in)
    );

    caldate_leap #(.YEAR_BITS(YEAR_BITS)) u_leap_cur (
        .year (cur_year),
        .leap (leap_cur)
    );

    assign len_in     = caldate_pkg::month_len(month_in, leap_in);
    assign len_cur    = caldate_pkg::month_len(cur_month, leap_cur);
    assign month_prev = cur_month - caldate_pkg::MONTH_BITS'(1);
    assign len_prev   = caldate_pkg::month_len(month_prev, leap_cur);
    assign load_ok    = (len_in != caldate_pkg::LEN_NONE) && (day_in != '0) &&
                        (day_in <= len_in) && (32'(year_in) >= YEAR_MIN);

    always_comb begin
        day_new   = cur_day;
        month_new = cur_month;
        year_new  = cur_year;
        flags     = '0;
        unique case (op)
            caldate_pkg::OP_LOAD: begin
                if (load_ok) begin
                    day_new   = day_in;
                    month_new = month_in;
                    year_new  = year_in;
                end else begin
                    day_new        = caldate_pkg::DEFAULT_DAY;
                    month_new      = caldate_pkg::DEFAULT_MONTH;
                    year_new       = YEAR_DFLT;
                    flags.rejected = 1'b1;
                end
            end
            caldate_pkg::OP_NEXT: begin
                priority if (cur_day < len_cur) begin
                    day_new = cur_day + caldate_pkg::DAY_BITS'(1);
                end else if (cur_month >= caldate_pkg::MONTH_DEC) begin
                    // hold at the top of the year range
                    if (cur_year != YEAR_MAX) begin
                        year_new  = cur_year + YEAR_BITS'(1);
                        month_new = caldate_pkg::MONTH_JAN;
                        day_new   = caldate_pkg::DEFAULT_DAY;
                    end
                end else begin
                    month_new = cur_month + caldate_pkg::MONTH_BITS'(1);
                    day_new   = caldate_pkg::DEFAULT_DAY;
                end
            end
            caldate_pkg::OP_PREV: begin
                priority if (cur_day > caldate_pkg::DAY_BITS'(1)) begin
                    day_new = cur_day - caldate_pkg::DAY_BITS'(1);
                end else if (cur_month <= caldate_pkg::MONTH_JAN) begin
                    if (cur_year != '0) begin
                        year_new  = cur_year - YEAR_BITS'(1);
                        month_new = caldate_pkg::MONTH_DEC;
                        day_new   = caldate_pkg::LEN_LONG;
                    end
                end else begin
                    month_new = month_prev;
                    day_new   = len_prev;
                end
            end
            caldate_pkg::OP_CMP: begin
                priority if (cur_year != year_in) begin
                    flags.earlier = (cur_year < year_in);
                end else if (cur_month != month_in) begin
                    flags.earlier = (cur_month < month_in);
                end else if (cur_day != day_in) begin
                    flags.earlier = (cur_day < day_in);
                end else begin
                    flags.equal = 1'b1;
                end
            end
            default: begin
                flags = '0;
            end
        endcase
    end

endmodule

// ----- hdl/calendar_date_up_down_counter_core.sv -----
// Gregorian date counter with a stream interface.
// Input transaction: s_axis_tuser selects the operation (load, next day,
// previous day, compare); s_axis_tdata carries the day, month and year used
// by load and compare. Every input transaction gives exactly one output
// transaction on m_axis with the stored date after the operation and the
// load-rejected, earlier and equal flags.
// m_axis_tvalid rises after the input transaction is accepted: the input
// register takes it, then the date update writes the result register.
// Throughput is one transaction per cycle while the output is not stalled
// by m_axis_tready; the path that sets it is the combinational update of
// the date register (month length, leap test by one multiply, carry).
// Reset (aresetn low, synchronous) empties both registers and sets the
// stored date to 1 January 1999. When m_axis_tready is low the result holds
// in the output register; one more transaction is taken into the input
// register, after which s_axis_tready drops until the result is taken.
// YEAR_BITS sets the stored year width; the year fields on the ports stay
// 16 bits and are zero-extended or truncated.
module calendar_date_up_down_counter_core #(
    parameter int YEAR_BITS     = 16,
    parameter int MIN_LOAD_YEAR = 1000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // day_in[4:0], month_in[8:5], year_in[24:9], zero
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // day_out[4:0], month_out[8:5], year_out[24:9],
                                        // load_rejected[25], is_earlier[26],
                                        // is_equal[27], zero
);

    localparam int DW = caldate_pkg::DAY_BITS;
    localparam int MW = caldate_pkg::MONTH_BITS;
    localparam int PW = caldate_pkg::YEAR_PORT_BITS;

    // input register
    logic                     in_vld_reg;
    caldate_pkg::caldate_op_t in_op_reg;
    logic [DW-1:0]            in_day_reg;
    logic [MW-1:0]            in_month_reg;
    logic [PW-1:0]            in_year_reg;

    // date state
    logic [DW-1:0]            cur_day_reg,   cur_day_next;
    logic [MW-1:0]            cur_month_reg, cur_month_next;
    logic [YEAR_BITS-1:0]     cur_year_reg,  cur_year_next;

    // result register
    logic                        out_vld_reg;
    logic [DW-1:0]               out_day_reg;
    logic [MW-1:0]               out_month_reg;
    logic [PW-1:0]               out_year_reg;
    caldate_pkg::caldate_flags_t out_flags_reg;

    caldate_pkg::caldate_flags_t flags;
    logic                        advance;
    logic                        s_accept;

    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg    <= caldate_pkg::caldate_op_t'(s_axis_tuser);
            in_day_reg   <= s_axis_tdata[4:0];
            in_month_reg <= s_axis_tdata[8:5];
            in_year_reg  <= s_axis_tdata[24:9];
        end
    end

    caldate_update #(
        .YEAR_BITS     (YEAR_BITS),
        .MIN_LOAD_YEAR (MIN_LOAD_YEAR)
    ) u_update (
        .op        (in_op_reg),
        .day_in    (in_day_reg),
        .month_in  (in_month_reg),
        .year_in   (YEAR_BITS'(in_year_reg)),
        .cur_day   (cur_day_reg),
        .cur_month (cur_month_reg),
        .cur_year  (cur_year_reg),
        .day_new   (cur_day_next),
        .month_new (cur_month_next),
        .year_new  (cur_year_next),
        .flags     (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_day_reg   <= caldate_pkg::DEFAULT_DAY;
            cur_month_reg <= caldate_pkg::DEFAULT_MONTH;
            cur_year_reg  <= YEAR_BITS'(caldate_pkg::DEFAULT_YEAR);
        end else if (advance) begin
            cur_day_reg   <= cur_day_next;
            cur_month_reg <= cur_month_next;
            cur_year_reg  <= cur_year_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_day_reg   <= cur_day_next;
            out_month_reg <= cur_month_next;
            out_year_reg  <= PW'(cur_year_next);
            out_flags_reg <= flags;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, out_flags_reg.equal, out_flags_reg.earlier,
                            out_flags_reg.rejected, out_year_reg, out_month_reg,
                            out_day_reg};

`ifndef SYNTH
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_month_reg >= caldate_pkg::MONTH_JAN) && (cur_month_reg <= caldate_pkg::MONTH_DEC))
        else $error("stored month out of range");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_day_reg != '0) && (cur_day_reg <= caldate_pkg::LEN_LONG))
        else $error("stored day out of range");

    a_reject_default: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_flags_reg.rejected) |->
        (out_day_reg == caldate_pkg::DEFAULT_DAY) &&
        (out_month_reg == caldate_pkg::DEFAULT_MONTH) &&
        (out_year_reg == PW'(caldate_pkg::DEFAULT_YEAR)))
        else $error("rejected load without default date");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> $onehot0({out_flags_reg.rejected, out_flags_reg.earlier,
                                  out_flags_reg.equal}))
        else $error("more than one result flag set");

    a_compare_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_op_reg == caldate_pkg::OP_CMP)) |=>
        ($stable(cur_day_reg) && $stable(cur_month_reg) && $stable(cur_year_reg)))
        else $error("compare changed the stored date");
`endif

endmodule
